>>> hw/rtl/qkx_pkg.sv
// ----------------------------------------------------------------------------
// qkx_pkg
// Shared constants and helpers for the Q4_K eight-row interleave buffer.
// ----------------------------------------------------------------------------
package qkx_pkg;

  localparam int unsigned GROUP_ROWS   = 8;
  localparam int unsigned BLOCK_VALUES = 256;
  localparam int unsigned QUANT_BYTES  = BLOCK_VALUES / 2;
  localparam int unsigned QUANT_WORDS  = QUANT_BYTES * GROUP_ROWS / 8;
  localparam int unsigned SCALE_PARTS  = 3;
  localparam int unsigned SCALE_DEPTH  = 4;

  localparam logic [7:0] OFF_MIN     = 8'd2;
  localparam logic [7:0] OFF_SCALE   = 8'd4;
  localparam logic [7:0] OFF_QUANT   = 8'd16;
  localparam logic [7:0] OFF_END     = 8'd144;
  localparam logic [7:0] MAP_SCALES  = 8'd128;
  localparam logic [7:0] MAP_DELTAS  = 8'd140;
  localparam logic [7:0] MAP_UNPACK  = 8'd144;
  localparam logic [7:0] MAP_FLOATS  = 8'd160;
  localparam logic [7:0] MAP_END     = 8'd168;

  localparam logic       CMD_LOAD = 1'b0;
  localparam logic       CMD_READ = 1'b1;

  // exact IEEE half to single
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [4:0] ex;
    logic [9:0] man;
    logic [9:0] nm;
    logic [3:0] p;
    logic [7:0] e;
    logic [31:0] res;
    ex  = h[14:10];
    man = h[9:0];
    p   = 4'd0;
    for (int k = 0; k < 10; k++) begin
      if (man[k]) p = 4'(k);
    end
    if (ex == 5'd0) begin
      if (man == 10'd0) begin
        res = {h[15], 31'd0};
      end else begin
        nm  = man << (4'd10 - p);
        e   = 8'd103 + {4'd0, p};
        res = {h[15], e, nm, 13'd0};
      end
    end else if (ex == 5'd31) begin
      res = {h[15], 8'hff, man, 13'd0};
    end else begin
      e   = {3'd0, ex} + 8'd112;
      res = {h[15], e, man, 13'd0};
    end
    return res;
  endfunction

  // repacked table byte -> {12-byte group, byte within group}
  function automatic logic [6:0] table_pos(input logic [6:0] t);
    logic [2:0] g;
    logic [6:0] base;
    g = 3'd0;
    for (int k = 1; k < 8; k++) begin
      if (t >= 7'(12 * k)) g = 3'(k);
    end
    base = {1'b0, g, 3'b000} + {2'b00, g, 2'b00};
    return {g, 4'(t - base)};
  endfunction

endpackage

>>> hw/rtl/qkx_ram.sv
// ----------------------------------------------------------------------------
// qkx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qkx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> hw/rtl/q4_k_eight_row_interleave.sv
// ----------------------------------------------------------------------------
// q4_k_eight_row_interleave
// Byte-loaded buffer for eight Q4_K blocks; serves 64-bit repacked words.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  in       in   in_valid_i/in_stall_o  cmd, src_row, byte_offset, data_byte,
//                                       read_index
//  out      out  out_valid_o/out_stall_i read_word, bad_index
//
// A load does not stall the input, so the next word is taken right after it.
// A read of quants, halves, floats or a bad index waits for the RAM read data,
// then goes to res_q and the output register; a read of scale words first sweeps
// the 4 scale RAM addresses into acc_q before res_q takes the word.
// Input stalls from read accept until the output register takes the word.
// Reset clears the control and datapath registers; stores are undefined until loaded.
module q4_k_eight_row_interleave
  import qkx_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [2:0]  src_row_i,
  input  logic [7:0]  byte_offset_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  read_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] read_word_o,
  output logic        bad_index_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_e;
  typedef enum logic [2:0] {
    CL_QUANT, CL_REPACK, CL_HALVES, CL_UNPACK, CL_FLOAT, CL_BAD
  } cls_e;

  state_e      state_q, state_d;
  logic [7:0]  idx_q, idx_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [1:0]  rd_cnt_q, rd_cnt_d;
  logic        rd_vld_q, rd_vld_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] res_q, res_d;
  logic        res_bad_q, res_bad_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] word_q, word_d;
  logic        bad_q, bad_d;

  logic [15:0] delta_q [GROUP_ROWS];
  logic [15:0] min_q   [GROUP_ROWS];

  logic        in_acc, ld;
  logic [7:0]  q_off, s_off;
  logic [7:0]  q_rd [8];
  logic [7:0]  sc_rd [SCALE_PARTS][GROUP_ROWS];
  logic [63:0] quant_word;
  cls_e        cls;
  logic        finish;
  logic [63:0] fin_word;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ld         = in_acc && (cmd_i == CMD_LOAD);
  assign q_off      = byte_offset_i - OFF_QUANT;
  assign s_off      = byte_offset_i - OFF_SCALE;

  for (genvar l = 0; l < 8; l++) begin : g_qlane
    qkx_ram #(.WIDTH(8), .DEPTH(QUANT_WORDS)) u_qram (
      .clk_i  (clk_i),
      .we_i   (ld && byte_offset_i >= OFF_QUANT && byte_offset_i < OFF_END
               && q_off[2:0] == 3'(l)),
      .waddr_i({q_off[6:3], src_row_i}),
      .wdata_i(data_byte_i),
      .raddr_i(idx_q[6:0]),
      .rdata_o(q_rd[l])
    );
    assign quant_word[l*8 +: 8] = q_rd[l];
  end

  for (genvar p = 0; p < SCALE_PARTS; p++) begin : g_spart
    for (genvar r = 0; r < GROUP_ROWS; r++) begin : g_srow
      qkx_ram #(.WIDTH(8), .DEPTH(SCALE_DEPTH)) u_sram (
        .clk_i  (clk_i),
        .we_i   (ld && byte_offset_i >= OFF_SCALE && byte_offset_i < OFF_QUANT
                 && s_off[3:2] == 2'(p) && src_row_i == 3'(r)),
        .waddr_i(s_off[1:0]),
        .wdata_i(data_byte_i),
        .raddr_i(cnt_q),
        .rdata_o(sc_rd[p][r])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld && byte_offset_i < OFF_MIN) begin
      if (byte_offset_i[0]) delta_q[src_row_i][15:8] <= data_byte_i;
      else delta_q[src_row_i][7:0] <= data_byte_i;
    end
    if (ld && byte_offset_i >= OFF_MIN && byte_offset_i < OFF_SCALE) begin
      if (byte_offset_i[0]) min_q[src_row_i][15:8] <= data_byte_i;
      else min_q[src_row_i][7:0] <= data_byte_i;
    end
  end

  always_comb begin
    if (idx_q < MAP_SCALES)      cls = CL_QUANT;
    else if (idx_q < MAP_DELTAS) cls = CL_REPACK;
    else if (idx_q < MAP_UNPACK) cls = CL_HALVES;
    else if (idx_q < MAP_FLOATS) cls = CL_UNPACK;
    else if (idx_q < MAP_END)    cls = CL_FLOAT;
    else                         cls = CL_BAD;
  end

  // scale sweep: rd_cnt_q is the scale byte index i of this cycle's data
  always_comb begin
    logic [7:0] sv [2][GROUP_ROWS];
    logic [7:0] mv [2][GROUP_ROWS];
    logic [7:0] gb [2][12];
    logic [6:0] tp;
    logic [2:0] ur;
    acc_d = acc_q;
    tp    = '0;
    for (int r = 0; r < GROUP_ROWS; r++) begin
      sv[0][r] = {2'b00, sc_rd[0][r][5:0]};
      mv[0][r] = {2'b00, sc_rd[1][r][5:0]};
      sv[1][r] = {2'b00, sc_rd[0][r][7:6], sc_rd[2][r][3:0]};
      mv[1][r] = {2'b00, sc_rd[1][r][7:6], sc_rd[2][r][7:4]};
    end
    for (int h = 0; h < 2; h++) begin
      for (int j = 0; j < 4; j++) begin
        gb[h][j]     = {sv[h][j+4][5:4], sv[h][j][5:0]};
        gb[h][4+j]   = {mv[h][j+4][5:4], mv[h][j][5:0]};
        gb[h][8+j]   = {mv[h][j+4][3:0], sv[h][j+4][3:0]};
      end
    end
    ur = idx_q[3:1];
    if (rd_vld_q && cls == CL_REPACK) begin
      for (int p = 0; p < 8; p++) begin
        tp = table_pos({idx_q[3:0], 3'b000} + 7'(p));
        if (tp[5:4] == rd_cnt_q) acc_d[p*8 +: 8] = gb[tp[6]][tp[3:0]];
      end
    end
    if (rd_vld_q && cls == CL_UNPACK) begin
      if (idx_q[0]) begin
        acc_d[{1'b0, rd_cnt_q, 3'b000} +: 8] = {2'b00, sc_rd[1][ur][5:0]};
        acc_d[{1'b1, rd_cnt_q, 3'b000} +: 8] =
          {2'b00, sc_rd[1][ur][7:6], sc_rd[2][ur][7:4]};
      end else begin
        acc_d[{1'b0, rd_cnt_q, 3'b000} +: 8] = {2'b00, sc_rd[0][ur][5:0]};
        acc_d[{1'b1, rd_cnt_q, 3'b000} +: 8] =
          {2'b00, sc_rd[0][ur][7:6], sc_rd[2][ur][3:0]};
      end
    end
  end

  always_comb begin
    logic [2:0] hb;
    hb = {idx_q[0], 2'b00};
    case (cls)
      CL_QUANT:  fin_word = quant_word;
      CL_REPACK, CL_UNPACK: fin_word = acc_d;
      CL_HALVES: begin
        if (idx_q[1]) begin
          fin_word = {min_q[hb + 3'd3], min_q[hb + 3'd2], min_q[hb + 3'd1], min_q[hb]};
        end else begin
          fin_word = {delta_q[hb + 3'd3], delta_q[hb + 3'd2],
                      delta_q[hb + 3'd1], delta_q[hb]};
        end
      end
      CL_FLOAT:  fin_word = {half_to_single(min_q[idx_q[2:0]]),
                             half_to_single(delta_q[idx_q[2:0]])};
      default:   fin_word = 64'd0;
    endcase
  end

  assign finish = (state_q == ST_RUN) && rd_vld_q &&
                  (rd_cnt_q == 2'd3 || !(cls == CL_REPACK || cls == CL_UNPACK));

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    rd_cnt_d    = rd_cnt_q;
    rd_vld_d    = rd_vld_q;
    res_d       = res_q;
    res_bad_d   = res_bad_q;
    out_valid_d = out_valid_q && out_stall_i;
    word_d      = word_q;
    bad_d       = bad_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && cmd_i == CMD_READ) begin
          idx_d    = read_index_i;
          cnt_d    = 2'd0;
          rd_vld_d = 1'b0;
          state_d  = ST_RUN;
        end
      end
      ST_RUN: begin
        cnt_d    = cnt_q + 2'd1;
        rd_cnt_d = cnt_q;
        rd_vld_d = 1'b1;
        if (finish) begin
          res_d     = fin_word;
          res_bad_d = (cls == CL_BAD);
          rd_vld_d  = 1'b0;
          state_d   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          word_d      = res_q;
          bad_d       = res_bad_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      rd_cnt_q    <= '0;
      rd_vld_q    <= 1'b0;
      acc_q       <= '0;
      res_q       <= '0;
      res_bad_q   <= 1'b0;
      out_valid_q <= 1'b0;
      word_q      <= '0;
      bad_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      rd_cnt_q    <= rd_cnt_d;
      rd_vld_q    <= rd_vld_d;
      acc_q       <= (state_q == ST_IDLE) ? 64'd0 : acc_d;
      res_q       <= res_d;
      res_bad_q   <= res_bad_d;
      out_valid_q <= out_valid_d;
      word_q      <= word_d;
      bad_q       <= bad_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_word_o = word_q;
  assign bad_index_o = bad_q;

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_index_o |-> read_word_o == 64'd0)
    else $error("bad index word not zero");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && cmd_i == CMD_READ |=> in_stall_o)
    else $error("input not stalled after read accept");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && cmd_i == CMD_LOAD && !out_valid_o |=> !out_valid_o)
    else $error("load produced a result");

endmodule
